FILE: hw/rtl/rfg_pkg.sv
// Shared types, constants and the color wheel function for the rainbow frame generator.
// No dependencies; used by rainbow_frame_generator_top.
`timescale 1ns / 1ps
`default_nettype none
package rfg_pkg;

   localparam int PIX_W       = 6;   // pixel index width
   localparam int COUNT_W     = 7;   // pixel count width (holds 0..127, used as 1..64)
   localparam int COLOR_W     = 8;
   localparam int OFFSET_W    = 11;  // frame offset, up to 1279
   localparam int QUOT_W      = 8;   // wheel position bits, quotient bits
   localparam int MAX_PIXELS_DEF = 64;

   localparam logic [OFFSET_W-1:0] EVEN_PERIOD = OFFSET_W'(256 * 5);

   localparam int CSR_IDX_W   = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_PIXELS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPREAD_MODE = 1'b1;

   localparam logic [COUNT_W-1:0] NUM_PIXELS_RST = COUNT_W'(64);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_DIV   = 4'b0010,
      S_COLOR = 4'b0100,
      S_OUT   = 4'b1000
   } state_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_type;

   // Three-segment wheel: red -> green -> blue -> red
   function automatic rgb_type wheel(input logic [QUOT_W-1:0] pos);
      rgb_type    c;
      logic [7:0] w;
      logic [7:0] seg;
      logic [9:0] w3;
      begin
         w = 8'd255 - pos;
         if (w < 8'd85) begin
            seg = w;
         end else if (w < 8'd170) begin
            seg = w - 8'd85;
         end else begin
            seg = w - 8'd170;
         end
         w3 = {2'b00, seg} + {1'b0, seg, 1'b0};
         if (w < 8'd85) begin
            c.red   = 8'd255 - w3[7:0];
            c.green = 8'd0;
            c.blue  = w3[7:0];
         end else if (w < 8'd170) begin
            c.red   = 8'd0;
            c.green = w3[7:0];
            c.blue  = 8'd255 - w3[7:0];
         end else begin
            c.red   = w3[7:0];
            c.green = 8'd255 - w3[7:0];
            c.blue  = 8'd0;
         end
         return c;
      end
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/rainbow_frame_generator_top.sv
// Rainbow frame generator: one frame tick in, one colored item per pixel out.
// Depends on rfg_pkg (types, constants, wheel function).
//
//   channel   dir   handshake            payload
//   req_      in    tvalid/tready        tdata[0] restart
//   rsp_      out   tvalid/tready/tlast  tdata: pixel_index, red, green, blue; tlast last_pixel
//   csr_      in    valid/ready          index, data
//
// Each pixel runs through the shared restoring divider (S_DIV), then the color
// step (S_COLOR), then waits in the output register (S_OUT) until taken; the
// next pixel starts only after that, and after the last pixel the block
// returns to S_IDLE to take the next frame tick.
// req_tready is high only while idle; a stalled rsp_ holds the sequencer.
// Synchronous active-high reset; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module rainbow_frame_generator_top #(
   parameter int MAX_PIXELS = rfg_pkg::MAX_PIXELS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [0] restart, [7:1] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [5:0] pixel_index, [13:6] red,
                                         // [21:14] green, [29:22] blue, [31:30] zero
   output logic             rsp_tlast,   // last_pixel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [rfg_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rfg_pkg::COUNT_W-1:0]   csr_data
);

   localparam logic [rfg_pkg::COUNT_W-1:0] MAX_N = rfg_pkg::COUNT_W'(MAX_PIXELS);

   rfg_pkg::state_type state_ff, state_in;

   logic [rfg_pkg::COUNT_W-1:0]  num_pixels_ff, num_pixels_in;
   logic                         spread_ff, spread_in;
   logic [rfg_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic [rfg_pkg::COUNT_W-1:0]  n_ff, n_in;
   logic [rfg_pkg::PIX_W-1:0]    pix_ff, pix_in;
   logic [rfg_pkg::COUNT_W-1:0]  rem_ff, rem_in;
   logic [rfg_pkg::QUOT_W-1:0]   quot_ff, quot_in;
   logic [2:0]                   step_ff, step_in;
   logic                         last_ff, last_in;
   rfg_pkg::rgb_type             rgb_ff, rgb_in;
   logic [rfg_pkg::PIX_W-1:0]    opix_ff, opix_in;

   logic                         req_acc, rsp_acc;
   logic [rfg_pkg::COUNT_W-1:0]  n_eff;
   logic [rfg_pkg::COUNT_W:0]    rem_sh;
   logic                         rem_ge;
   logic [rfg_pkg::QUOT_W-1:0]   base, pos;
   logic [rfg_pkg::OFFSET_W-1:0] offset_inc;
   logic                         is_last;

   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == rfg_pkg::S_IDLE);
   assign rsp_tvalid = (state_ff == rfg_pkg::S_OUT);
   assign csr_ready  = 1'b1;
   assign rsp_tdata  = {2'b00, rgb_ff.blue, rgb_ff.green, rgb_ff.red, opix_ff};
   assign rsp_tlast  = last_ff;

   always_comb begin
      if (num_pixels_ff == '0) begin
         n_eff = rfg_pkg::COUNT_W'(1);
      end else if (num_pixels_ff > MAX_N) begin
         n_eff = MAX_N;
      end else begin
         n_eff = num_pixels_ff;
      end
   end

   // one restoring step of (pix * 256) / n; remainder stays below n
   assign rem_sh = {rem_ff, 1'b0};
   assign rem_ge = (rem_sh >= {1'b0, n_ff});

   assign base       = spread_ff ? quot_ff : {2'b00, pix_ff};
   assign pos        = base + offset_ff[rfg_pkg::QUOT_W-1:0];
   assign offset_inc = offset_ff + rfg_pkg::OFFSET_W'(1);
   assign is_last    = ({1'b0, pix_ff} == n_ff - rfg_pkg::COUNT_W'(1));

   always_comb begin
      state_in      = state_ff;
      num_pixels_in = num_pixels_ff;
      spread_in     = spread_ff;
      offset_in     = offset_ff;
      n_in          = n_ff;
      pix_in        = pix_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      last_in       = last_ff;
      rgb_in        = rgb_ff;
      opix_in       = opix_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            rfg_pkg::CSR_NUM_PIXELS:  num_pixels_in = csr_data;
            rfg_pkg::CSR_SPREAD_MODE: spread_in     = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         rfg_pkg::S_IDLE: begin
            if (req_acc) begin
               if (req_tdata[0]) begin
                  offset_in = '0;
               end
               n_in     = n_eff;
               pix_in   = '0;
               rem_in   = '0;
               quot_in  = '0;
               step_in  = '0;
               state_in = rfg_pkg::S_DIV;
            end
         end
         rfg_pkg::S_DIV: begin
            rem_in  = rem_ge ? rem_sh[rfg_pkg::COUNT_W-1:0] - n_ff
                             : rem_sh[rfg_pkg::COUNT_W-1:0];
            quot_in = {quot_ff[rfg_pkg::QUOT_W-2:0], rem_ge};
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               state_in = rfg_pkg::S_COLOR;
            end
         end
         rfg_pkg::S_COLOR: begin
            rgb_in   = rfg_pkg::wheel(pos);
            opix_in  = pix_ff;
            last_in  = is_last;
            state_in = rfg_pkg::S_OUT;
         end
         rfg_pkg::S_OUT: begin
            if (rsp_acc) begin
               if (last_ff) begin
                  if (spread_ff) begin
                     offset_in = (offset_inc == rfg_pkg::EVEN_PERIOD) ? '0 : offset_inc;
                  end else begin
                     offset_in = {3'b000, offset_inc[rfg_pkg::QUOT_W-1:0]};
                  end
                  state_in = rfg_pkg::S_IDLE;
               end else begin
                  pix_in   = pix_ff + rfg_pkg::PIX_W'(1);
                  rem_in   = {1'b0, pix_ff + rfg_pkg::PIX_W'(1)};
                  quot_in  = '0;
                  step_in  = '0;
                  state_in = rfg_pkg::S_DIV;
               end
            end
         end
         default: state_in = rfg_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rfg_pkg::S_IDLE;
         num_pixels_ff <= rfg_pkg::NUM_PIXELS_RST;
         spread_ff     <= 1'b1;
         offset_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         num_pixels_ff <= num_pixels_in;
         spread_ff     <= spread_in;
         offset_ff     <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      pix_ff  <= pix_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
      last_ff <= last_in;
      rgb_ff  <= rgb_in;
      opix_ff <= opix_in;
   end

`ifndef SYNTHESIS
   a_rem_below_n: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfg_pkg::S_DIV) |-> (rem_ff < n_ff))
      else $error("divider remainder not below pixel count");

   a_pix_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff != rfg_pkg::S_IDLE) |-> ({1'b0, pix_ff} < n_ff))
      else $error("pixel index beyond frame");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_tlast) |=> req_tready)
      else $error("frame did not end after last pixel");

   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      offset_ff < rfg_pkg::EVEN_PERIOD)
      else $error("frame offset out of range");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while result pending");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking bench for rainbow_frame_generator_top: frame ticks in, pixel items out.
// Depends on rfg_pkg and the RTL; a small class predicts every pixel and checks the stream.
`timescale 1ns / 1ps
module tb_top;

   localparam int PLAIN_PERIOD = 256;
   localparam int HOLD_CYCLES  = 400;

   typedef struct {
      logic [rfg_pkg::PIX_W-1:0] index;
      rfg_pkg::rgb_type          color;
      logic                      last;
   } pixel_type;

   // Tracks strip settings and frame offset, and holds the pixels still to come.
   class strip_colors;
      logic [rfg_pkg::COUNT_W-1:0]  num_pixels;
      logic                         spread;
      logic [rfg_pkg::OFFSET_W-1:0] offset;
      pixel_type                    pixels_due[$];
      int                           errors;

      function new();
         num_pixels = rfg_pkg::NUM_PIXELS_RST;
         spread     = 1'b1;
         offset     = '0;
         errors     = 0;
      endfunction

      function void set_reg(logic [rfg_pkg::CSR_IDX_W-1:0] idx,
                            logic [rfg_pkg::COUNT_W-1:0] data);
         if (idx == rfg_pkg::CSR_NUM_PIXELS) begin
            num_pixels = data;
         end else if (idx == rfg_pkg::CSR_SPREAD_MODE) begin
            spread = data[0];
         end
      endfunction

      function rfg_pkg::rgb_type color_at(int pos);
         rfg_pkg::rgb_type c;
         int w;
         w = 255 - pos;
         if (w < 85) begin
            c.red = 8'(255 - 3 * w); c.green = 8'd0; c.blue = 8'(3 * w);
         end else if (w < 170) begin
            w -= 85;
            c.red = 8'd0; c.green = 8'(3 * w); c.blue = 8'(255 - 3 * w);
         end else begin
            w -= 170;
            c.red = 8'(3 * w); c.green = 8'(255 - 3 * w); c.blue = 8'd0;
         end
         return c;
      endfunction

      function void add_frame(logic restart);
         int        n;
         int        base;
         pixel_type px;
         n = num_pixels;
         if (n < 1) n = 1;
         if (n > rfg_pkg::MAX_PIXELS_DEF) n = rfg_pkg::MAX_PIXELS_DEF;
         if (restart) offset = '0;
         for (int p = 0; p < n; p++) begin
            base     = spread ? (p * 256) / n : p;
            px.index = rfg_pkg::PIX_W'(p);
            px.color = color_at((base + int'(offset)) & 255);
            px.last  = (p == n - 1);
            pixels_due.push_back(px);
         end
         offset = rfg_pkg::OFFSET_W'((int'(offset) + 1) %
                  (spread ? int'(rfg_pkg::EVEN_PERIOD) : PLAIN_PERIOD));
      endfunction

      function int pending();
         return pixels_due.size();
      endfunction

      task report(string msg);
         $display("tb_top: mismatch: %s", msg);
         errors++;
      endtask

      task check_pixel(logic [31:0] data, logic last);
         pixel_type px;
         if (pixels_due.size() == 0) begin
            report($sformatf("unexpected item data=%h last=%b", data, last));
         end else begin
            px = pixels_due.pop_front();
            if (data[5:0] !== px.index)
               report($sformatf("pixel_index %0d, want %0d", data[5:0], px.index));
            if (data[13:6] !== px.color.red)
               report($sformatf("pixel %0d red %0d, want %0d", px.index, data[13:6],
                                px.color.red));
            if (data[21:14] !== px.color.green)
               report($sformatf("pixel %0d green %0d, want %0d", px.index, data[21:14],
                                px.color.green));
            if (data[29:22] !== px.color.blue)
               report($sformatf("pixel %0d blue %0d, want %0d", px.index, data[29:22],
                                px.color.blue));
            if (last !== px.last)
               report($sformatf("pixel %0d last_pixel %b, want %b", px.index, last, px.last));
         end
      endtask
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [7:0]                    req_tdata = '0;    // [0] restart, [7:1] zero
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [31:0]                   rsp_tdata;         // [5:0] pixel_index, [13:6] red,
                                                     // [21:14] green, [29:22] blue,
                                                     // [31:30] zero
   logic                          rsp_tlast;         // last_pixel
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [rfg_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rfg_pkg::COUNT_W-1:0]   csr_data = '0;

   logic                          no_idle = 1'b0;
   int                            hold_trig = 0;
   int                            hold_seen = 0;
   int                            hold_left = 0;
   int                            random_frames = 0;
   strip_colors                   sb = new();

   rainbow_frame_generator_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #10_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   // Output side: check on handshake, then pick the next ready value.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata, rsp_tlast);
      if (hold_trig != hold_seen) begin
         hold_seen = hold_trig;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 20);
      end
   end

   // Leaves req_tvalid high on return so back-to-back frames need no bubble.
   task automatic send_frame(logic restart);
      while (!no_idle && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, restart};
      do @(posedge clock); while (!req_tready);
      sb.add_frame(restart);
   endtask

   task automatic drain_frames();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Block must be idle; spread mode gets random upper data bits, only bit 0 counts.
   task automatic write_setup(int np, logic sm);
      logic [rfg_pkg::COUNT_W-1:0] sm_data;
      sm_data    = rfg_pkg::COUNT_W'($urandom);
      sm_data[0] = sm;
      csr_valid <= 1'b1;
      csr_index <= rfg_pkg::CSR_NUM_PIXELS;
      csr_data  <= rfg_pkg::COUNT_W'(np);
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(rfg_pkg::CSR_NUM_PIXELS, rfg_pkg::COUNT_W'(np));
      csr_index <= rfg_pkg::CSR_SPREAD_MODE;
      csr_data  <= sm_data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(rfg_pkg::CSR_SPREAD_MODE, sm_data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int pick_count();
      int r;
      r = $urandom_range(99);
      if (r < 60) return $urandom_range(1, 16);
      if (r < 75) return $urandom_range(17, 63);
      if (r < 85) return rfg_pkg::MAX_PIXELS_DEF;
      if (r < 93) return $urandom_range(65, 127);
      return 0;
   endfunction

   initial begin
      int np_list[8];
      bit sm_list[8];
      int group;
      int frames;
      np_list = '{1, 0, 127, 65, 64, 3, 37, 1};
      sm_list = '{0, 1, 0, 1, 0, 1, 1, 1};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: 64 pixels, even spread; restart clears a nonzero offset
      send_frame(1'b0);
      send_frame(1'b0);
      send_frame(1'b1);
      send_frame(1'b0);
      drain_frames();

      // count extremes (zero and above max saturate), both modes
      foreach (np_list[k]) begin
         write_setup(np_list[k], sm_list[k]);
         send_frame(k[0]);
         send_frame(~k[0]);
         drain_frames();
      end

      // single pixel shows the offset directly; offset carries across mode changes
      write_setup(1, 1'b1);
      send_frame(1'b1);
      repeat (5) send_frame(1'b0);
      drain_frames();
      write_setup(1, 1'b0);
      repeat (3) send_frame(1'b0);
      drain_frames();
      write_setup(2, 1'b1);
      repeat (3) send_frame(1'b0);
      drain_frames();

      group = 0;
      while (random_frames < 90) begin
         if (group == 3) begin
            write_setup(rfg_pkg::MAX_PIXELS_DEF, 1'($urandom_range(1)));
            hold_trig <= hold_trig + 1;
         end else begin
            write_setup(pick_count(), 1'($urandom_range(1)));
         end
         if (group == 1) no_idle <= 1'b1;
         frames = $urandom_range(3, 10);
         for (int f = 0; f < frames; f++) begin
            send_frame($urandom_range(99) < 15);
            random_frames++;
            if (group == 5 && f == 1) drain_frames();
         end
         drain_frames();
         if (group == 1) no_idle <= 1'b0;
         group++;
      end

      repeat (700) @(posedge clock);
      if (sb.pending() != 0) sb.report($sformatf("%0d items never came", sb.pending()));
      if (sb.errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
